// ----- rtl/core/nmeasv_pkg.sv -----
// shared types, character constants and helpers for the nmea sentence validator
package nmeasv_pkg;

  // framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // checksum digits
  localparam int unsigned HEX_RADIX = 16;
  localparam int unsigned HEX_BITS  = $clog2(HEX_RADIX);

  // header layout
  localparam int unsigned HDR_CHARS = 5;
  localparam int unsigned POS_MAX   = HDR_CHARS + 1;

  // talker and sentence names
  localparam logic [7:0]  NAME_P   = "P";
  localparam logic [15:0] NAME_WI  = "WI";
  localparam logic [15:0] NAME_GP  = "GP";
  localparam logic [15:0] NAME_GN  = "GN";
  localparam logic [23:0] NAME_GGA = "GGA";
  localparam logic [23:0] NAME_GLL = "GLL";
  localparam logic [23:0] NAME_GSA = "GSA";
  localparam logic [23:0] NAME_RMC = "RMC";

  typedef enum logic [2:0] {
    ST_BAD      = 3'd0,
    ST_DOLLAR   = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_TALKER   = 3'd3,
    ST_SENTENCE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    TK_NONE = 3'd0,
    TK_P    = 3'd1,
    TK_WI   = 3'd2,
    TK_GP   = 3'd3,
    TK_GN   = 3'd4
  } talker_e;

  typedef enum logic [2:0] {
    SN_NONE = 3'd0,
    SN_GGA  = 3'd1,
    SN_GLL  = 3'd2,
    SN_GSA  = 3'd3,
    SN_RMC  = 3'd4
  } sentence_e;

  // per-message parse state
  typedef struct packed {
    logic [2:0]                    byte_position;
    logic                          starts_with_dollar;
    logic [7:0]                    running_xor;
    logic [7:0]                    xor_before_star;
    logic                          star_seen;
    logic [1:0]                    bytes_after_star;
    logic [7:0]                    high_digit_char;
    logic [7:0]                    low_digit_char;
    logic [HDR_CHARS-1:0][7:0]     header_chars;
  } msg_state_t;

  // verdict for one message
  typedef struct packed {
    status_e   status;
    talker_e   talker;
    sentence_e sentence;
  } verdict_t;

  // hex digit value, anything but 0-9 and A-F reads as zero
  function automatic logic [HEX_BITS-1:0] hex_value(input logic [7:0] c);
    logic [HEX_BITS-1:0] v;
    v = '0;
    if (c inside {["0":"9"]}) begin
      v = HEX_BITS'(c - 8'h30);
    end else if (c inside {["A":"F"]}) begin
      v = HEX_BITS'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/nmea_sentence_validator.sv -----
// top level of the nmea sentence validator
//
// Input channel: one character word per handshake on data_byte_i, with
// last_byte_i high on the final character of a message. Output channel:
// one verdict word per message (status_level_o, talker_code_o,
// sentence_code_o), nothing for the other characters.
// A word is taken at a rising edge with valid high and stall low.
// The last character passes the input register, then its verdict is
// registered in the result register.
// Throughput: one character per cycle while no final character is held;
// the parse state and the checksum update together for each character.
// While the receiver stalls a pending verdict, non-final characters keep
// flowing; a final character waits in the input register with in_stall_o
// high until the result register frees.
// Reset clears the input and output valids and the whole parse state;
// the state is cleared again after every final character.
module nmea_sentence_validator
  import nmeasv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_level_o,
  output logic [2:0] talker_code_o,
  output logic [2:0] sentence_code_o
);

  logic       in_valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       accept;
  logic       consume;

  msg_state_t state_q, state_d;
  verdict_t   verdict;
  verdict_t   verdict_q;
  logic       out_valid_q;

  // input register handshake
  assign consume    = in_valid_q && (!last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // parse state update for the registered character
  always_comb begin
    state_d = state_q;
    if (state_q.byte_position == 3'd0) begin
      state_d.starts_with_dollar = (data_q == CH_DOLLAR);
    end else begin
      for (int i = 0; i < HDR_CHARS; i++) begin
        if (state_q.byte_position == 3'(i + 1)) begin
          state_d.header_chars[i] = data_q;
        end
      end
      if (data_q == CH_STAR) begin
        state_d.xor_before_star  = state_q.running_xor;
        state_d.star_seen        = 1'b1;
        state_d.bytes_after_star = 2'd0;
        state_d.high_digit_char  = '0;
        state_d.low_digit_char   = '0;
      end else if (state_q.star_seen && state_q.bytes_after_star < 2'd2) begin
        if (state_q.bytes_after_star == 2'd0) begin
          state_d.high_digit_char = data_q;
        end else begin
          state_d.low_digit_char = data_q;
        end
        state_d.bytes_after_star = state_q.bytes_after_star + 2'd1;
      end
      state_d.running_xor = state_q.running_xor ^ data_q;
    end
    if (state_q.byte_position < 3'(POS_MAX)) begin
      state_d.byte_position = state_q.byte_position + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (consume) begin
      if (last_q) begin
        state_q <= '0;
      end else begin
        state_q <= state_d;
      end
    end
  end

  // verdict on the state including the final character
  nmeasv_eval u_eval (
    .st_i      (state_d),
    .verdict_o (verdict)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && last_q) begin
      verdict_q <= verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_level_o  = verdict_q.status;
  assign talker_code_o   = verdict_q.talker;
  assign sentence_code_o = verdict_q.sentence;

  // position counter saturates at six
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_position <= 3'(POS_MAX))
    else $error("byte position beyond saturation");

  // state is cleared after the final character
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && last_q |=> state_q.byte_position == 3'd0 && !state_q.star_seen)
    else $error("parse state not cleared after message");

  // a talker is only reported at talker stage or beyond
  a_talker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_q.talker != TK_NONE) |->
      (verdict_q.status == ST_TALKER || verdict_q.status == ST_SENTENCE))
    else $error("talker code without talker status");

  // a sentence code goes with full status and nothing else
  a_sentence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((verdict_q.sentence != SN_NONE) == (verdict_q.status == ST_SENTENCE)))
    else $error("sentence code and status disagree");

  // a final character never overwrites a pending verdict
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && in_valid_q && last_q |-> !consume)
    else $error("verdict overwritten while stalled");

endmodule

// ----- rtl/core/nmeasv_eval.sv -----
// end-of-message evaluation: checksum compare, talker and sentence lookup
module nmeasv_eval
  import nmeasv_pkg::*;
(
  input  msg_state_t st_i,
  output verdict_t   verdict_o
);

  logic [7:0]  sum;
  logic        sum_ok;
  logic [23:0] name;

  // checksum from the two characters after the last star
  assign sum    = 8'({hex_value(st_i.high_digit_char), hex_value(st_i.low_digit_char)});
  assign sum_ok = st_i.star_seen && (st_i.bytes_after_star >= 2'd2)
                  && (sum == st_i.xor_before_star);

  always_comb begin
    verdict_o.status   = ST_BAD;
    verdict_o.talker   = TK_NONE;
    verdict_o.sentence = SN_NONE;
    name               = '0;
    if (st_i.starts_with_dollar) begin
      verdict_o.status = ST_DOLLAR;
      if (sum_ok) begin
        verdict_o.status = ST_CHECKSUM;
        // talker, single-letter prefix first
        if (st_i.header_chars[0] == NAME_P) begin
          verdict_o.talker = TK_P;
        end else if ({st_i.header_chars[0], st_i.header_chars[1]} == NAME_WI) begin
          verdict_o.talker = TK_WI;
        end else if ({st_i.header_chars[0], st_i.header_chars[1]} == NAME_GP) begin
          verdict_o.talker = TK_GP;
        end else if ({st_i.header_chars[0], st_i.header_chars[1]} == NAME_GN) begin
          verdict_o.talker = TK_GN;
        end
        // sentence name follows the talker
        if (verdict_o.talker == TK_P) begin
          name = {st_i.header_chars[1], st_i.header_chars[2], st_i.header_chars[3]};
        end else begin
          name = {st_i.header_chars[2], st_i.header_chars[3], st_i.header_chars[4]};
        end
        if (verdict_o.talker != TK_NONE) begin
          verdict_o.status = ST_TALKER;
          if (name == NAME_GGA) begin
            verdict_o.sentence = SN_GGA;
          end else if (name == NAME_GLL) begin
            verdict_o.sentence = SN_GLL;
          end else if (name == NAME_GSA) begin
            verdict_o.sentence = SN_GSA;
          end else if (name == NAME_RMC) begin
            verdict_o.sentence = SN_RMC;
          end
          if (verdict_o.sentence != SN_NONE) begin
            verdict_o.status = ST_SENTENCE;
          end
        end
      end
    end
  end

endmodule
